>>> rtl/core/gbe_pkg.sv
// Shared types and codes for the gap buffer editor.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package gbe_pkg;

   localparam int ACT_W    = 3;
   localparam int CHAR_W   = 8;
   localparam int COUNT_W  = 11;
   localparam int POS_W    = 10;
   localparam int STATUS_W = 2;
   localparam int LEN_W    = 11;

   localparam logic [ACT_W-1:0] ACT_INSERT  = 3'd0;
   localparam logic [ACT_W-1:0] ACT_DELETE  = 3'd1;
   localparam logic [ACT_W-1:0] ACT_FORWARD = 3'd2;
   localparam logic [ACT_W-1:0] ACT_REWIND  = 3'd3;
   localparam logic [ACT_W-1:0] ACT_READ    = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   // packed with the first field in the highest bits
   typedef struct packed {
      logic [POS_W-1:0]   position;
      logic [COUNT_W-1:0] count;
      logic [CHAR_W-1:0]  char_in;
      logic [ACT_W-1:0]   action;
   } req_type;

   typedef struct packed {
      logic [LEN_W-1:0]    cursor;
      logic [LEN_W-1:0]    text_length;
      logic [CHAR_W-1:0]   char_out;
      logic [STATUS_W-1:0] status;
   } result_type;

endpackage

>>> rtl/core/gap_buffer_editor_unit.sv
// Top level of the gap buffer editor: sequencer, byte store, result register.
// Depends on gbe_pkg, gbe_seq, gbe_store.
//
//   channel | dir | tdata fields (low bit up)                         | bits
//   req_    | in  | action[2:0] char_in[10:3] count[21:11] position[31:22] | 32
//   rsp_    | out | status[1:0] char_out[9:2] text_length[20:10] cursor[31:21] | 32
//
// Insert, delete and error results pass from accept through S_CHECK and S_RESULT;
// a read also passes S_ADDR (skipped left of the gap) and S_RD_WAIT (one registered
// store read). A cursor move loops S_COPY_RD and S_COPY_WR, one store read and one store write per copied byte.
// Reset restores an empty text with the cursor at zero; store contents are kept.
// A result waits in the output register while the next item is accepted.
`timescale 1ns / 1ps

module gap_buffer_editor_unit
   import gbe_pkg::*;
#(
   parameter int DEPTH = 1024
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [31:0]   req_tdata,   // action, char_in, count, position
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [31:0]   rsp_tdata    // status, char_out, text_length, cursor
);

   localparam int AW = $clog2(DEPTH);

   logic                 out_free;
   logic                 seq_rsp_valid;
   result_type           seq_rsp;
   logic                 rsp_valid_ff;
   result_type           rsp_data_ff;

   logic                 st_we;
   logic [AW-1:0]        st_waddr;
   logic [CHAR_W-1:0]    st_wdata;
   logic [AW-1:0]        st_raddr;
   logic [CHAR_W-1:0]    st_rdata;

   assign out_free = !rsp_valid_ff || rsp_tready;

   gbe_seq #(.DEPTH(DEPTH)) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req       (req_type'(req_tdata)),
      .req_ready (req_tready),
      .out_free  (out_free),
      .rsp_valid (seq_rsp_valid),
      .rsp       (seq_rsp),
      .st_we     (st_we),
      .st_waddr  (st_waddr),
      .st_wdata  (st_wdata),
      .st_raddr  (st_raddr),
      .st_rdata  (st_rdata)
   );

   gbe_store #(.DEPTH(DEPTH)) u_store (
      .clock (clock),
      .we    (st_we),
      .waddr (st_waddr),
      .wdata (st_wdata),
      .raddr (st_raddr),
      .rdata (st_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= seq_rsp_valid;
      end
      if (out_free && seq_rsp_valid) begin
         rsp_data_ff <= seq_rsp;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> rtl/core/gbe_alu.sv
// Shared add/subtract unit for pointer checks and address generation.
// Depends on gbe_pkg for the operation type.
`timescale 1ns / 1ps

module gbe_alu
   import gbe_pkg::*;
#(
   parameter int W = 12
) (
   input  alu_op_type     op,
   input  logic [W-1:0]   a,
   input  logic [W-1:0]   b,
   output logic [W-1:0]   y
);

   always_comb begin
      case (op)
         ALU_ADD: y = a + b;
         ALU_SUB: y = a - b;
         default: y = a + b;
      endcase
   end

endmodule

>>> rtl/core/gbe_store.sv
// Byte store of the gap buffer: one write port, one registered read port.
// Depends on gbe_pkg for the character width.
`timescale 1ns / 1ps

module gbe_store
   import gbe_pkg::*;
#(
   parameter int DEPTH = 1024
) (
   input  logic                       clock,
   input  logic                       we,
   input  logic [$clog2(DEPTH)-1:0]   waddr,
   input  logic [CHAR_W-1:0]          wdata,
   input  logic [$clog2(DEPTH)-1:0]   raddr,
   output logic [CHAR_W-1:0]          rdata
);

   logic [CHAR_W-1:0] mem [DEPTH];
   logic [CHAR_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/core/gbe_seq.sv
// Sequencer of the gap buffer editor: gap pointers, range checks, byte copy loop.
// Depends on gbe_pkg, gbe_alu; drives the byte store ports.
`timescale 1ns / 1ps

module gbe_seq
   import gbe_pkg::*;
#(
   parameter int DEPTH = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  req_type                    req,
   output logic                       req_ready,
   input  logic                       out_free,
   output logic                       rsp_valid,
   output result_type                 rsp,
   output logic                       st_we,
   output logic [$clog2(DEPTH)-1:0]   st_waddr,
   output logic [CHAR_W-1:0]          st_wdata,
   output logic [$clog2(DEPTH)-1:0]   st_raddr,
   input  logic [CHAR_W-1:0]          st_rdata
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int AW = $clog2(DEPTH);
   localparam int UW = ((CW > COUNT_W) ? CW : COUNT_W) + 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_ADDR,
      S_RD_WAIT,
      S_COPY_RD,
      S_COPY_WR,
      S_RESULT
   } state_type;

   state_type             state_ff;
   logic [CW-1:0]         gap_left_ff;
   logic [CW-1:0]         gap_right_ff;
   req_type               item_ff;
   logic [COUNT_W-1:0]    remain_ff;
   logic [STATUS_W-1:0]   status_ff;
   logic [CHAR_W-1:0]     char_ff;
   logic [UW-1:0]         tmp_ff;

   alu_op_type            alu_op;
   logic [UW-1:0]         alu_a;
   logic [UW-1:0]         alu_b;
   logic [UW-1:0]         alu_y;

   logic [UW-1:0]         gl_x;
   logic [UW-1:0]         gr_x;
   logic [UW-1:0]         cnt_x;
   logic [UW-1:0]         pos_x;
   logic [UW-1:0]         len_x;
   logic                  accept;

   assign gl_x   = {{(UW-CW){1'b0}}, gap_left_ff};
   assign gr_x   = {{(UW-CW){1'b0}}, gap_right_ff};
   assign cnt_x  = {{(UW-COUNT_W){1'b0}}, item_ff.count};
   assign pos_x  = {{(UW-POS_W){1'b0}}, item_ff.position};
   assign len_x  = gl_x + UW'(DEPTH) - gr_x;
   assign accept = req_valid && req_ready;

   gbe_alu #(.W(UW)) u_alu (
      .op (alu_op),
      .a  (alu_a),
      .b  (alu_b),
      .y  (alu_y)
   );

   always_comb begin
      alu_op = ALU_ADD;
      alu_a  = '0;
      alu_b  = '0;
      case (state_ff)
         S_CHECK: begin
            case (item_ff.action)
               ACT_INSERT: begin
                  alu_a = gl_x;
                  alu_b = UW'(1);
               end
               ACT_DELETE, ACT_REWIND: begin
                  alu_op = ALU_SUB;
                  alu_a  = gl_x;
                  alu_b  = cnt_x;
               end
               ACT_FORWARD: begin
                  alu_a = gr_x;
                  alu_b = cnt_x;
               end
               ACT_READ: begin
                  alu_op = ALU_SUB;
                  alu_a  = pos_x;
                  alu_b  = gl_x;
               end
               default: begin
                  alu_a = '0;
               end
            endcase
         end
         S_ADDR: begin
            alu_a = gr_x;
            alu_b = tmp_ff;
         end
         S_COPY_RD: begin
            if (item_ff.action == ACT_REWIND) begin
               alu_op = ALU_SUB;
               alu_a  = gl_x;
               alu_b  = UW'(1);
            end else begin
               alu_a = gr_x;
            end
         end
         S_COPY_WR: begin
            if (item_ff.action == ACT_REWIND) begin
               alu_op = ALU_SUB;
               alu_a  = gr_x;
               alu_b  = UW'(1);
            end else begin
               alu_a = gl_x;
            end
         end
         default: begin
            alu_a = '0;
         end
      endcase
   end

   always_comb begin
      st_we    = 1'b0;
      st_waddr = alu_y[AW-1:0];
      st_wdata = st_rdata;
      st_raddr = alu_y[AW-1:0];
      case (state_ff)
         S_CHECK: begin
            if (item_ff.action == ACT_INSERT && gap_left_ff != gap_right_ff) begin
               st_we    = 1'b1;
               st_waddr = gap_left_ff[AW-1:0];
               st_wdata = item_ff.char_in;
            end
            if (item_ff.action == ACT_READ) begin
               st_raddr = pos_x[AW-1:0];
            end
         end
         S_COPY_WR: begin
            st_we = 1'b1;
         end
         default: begin
            st_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         gap_left_ff  <= '0;
         gap_right_ff <= CW'(DEPTH);
         status_ff    <= ST_OK;
         char_ff      <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  item_ff   <= req;
                  status_ff <= ST_OK;
                  char_ff   <= '0;
                  state_ff  <= S_CHECK;
               end
            end
            S_CHECK: begin
               case (item_ff.action)
                  ACT_INSERT: begin
                     if (gap_left_ff == gap_right_ff) begin
                        status_ff <= ST_FULL;
                     end else begin
                        gap_left_ff <= alu_y[CW-1:0];
                     end
                     state_ff <= S_RESULT;
                  end
                  ACT_DELETE: begin
                     if (alu_y[UW-1]) begin
                        status_ff <= ST_RANGE;
                     end else begin
                        gap_left_ff <= alu_y[CW-1:0];
                     end
                     state_ff <= S_RESULT;
                  end
                  ACT_FORWARD: begin
                     remain_ff <= item_ff.count;
                     if (alu_y > UW'(DEPTH)) begin
                        status_ff <= ST_RANGE;
                        state_ff  <= S_RESULT;
                     end else if (item_ff.count == '0) begin
                        state_ff <= S_RESULT;
                     end else begin
                        state_ff <= S_COPY_RD;
                     end
                  end
                  ACT_REWIND: begin
                     remain_ff <= item_ff.count;
                     if (alu_y[UW-1]) begin
                        status_ff <= ST_RANGE;
                        state_ff  <= S_RESULT;
                     end else if (item_ff.count == '0) begin
                        state_ff <= S_RESULT;
                     end else begin
                        state_ff <= S_COPY_RD;
                     end
                  end
                  ACT_READ: begin
                     tmp_ff <= alu_y;
                     if (alu_y[UW-1]) begin
                        state_ff <= S_RD_WAIT;
                     end else begin
                        state_ff <= S_ADDR;
                     end
                  end
                  default: begin
                     status_ff <= ST_RANGE;
                     state_ff  <= S_RESULT;
                  end
               endcase
            end
            S_ADDR: begin
               if (alu_y >= UW'(DEPTH)) begin
                  status_ff <= ST_RANGE;
                  state_ff  <= S_RESULT;
               end else begin
                  state_ff <= S_RD_WAIT;
               end
            end
            S_RD_WAIT: begin
               char_ff  <= st_rdata;
               state_ff <= S_RESULT;
            end
            S_COPY_RD: begin
               state_ff <= S_COPY_WR;
            end
            S_COPY_WR: begin
               if (item_ff.action == ACT_REWIND) begin
                  gap_left_ff  <= gap_left_ff - CW'(1);
                  gap_right_ff <= gap_right_ff - CW'(1);
               end else begin
                  gap_left_ff  <= gap_left_ff + CW'(1);
                  gap_right_ff <= gap_right_ff + CW'(1);
               end
               remain_ff <= remain_ff - COUNT_W'(1);
               if (remain_ff == COUNT_W'(1)) begin
                  state_ff <= S_RESULT;
               end else begin
                  state_ff <= S_COPY_RD;
               end
            end
            S_RESULT: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = (state_ff == S_RESULT);
   assign rsp.status      = status_ff;
   assign rsp.char_out    = char_ff;
   assign rsp.text_length = len_x[LEN_W-1:0];
   assign rsp.cursor      = gl_x[LEN_W-1:0];

   a_gap_order: assert property (@(posedge clock) disable iff (reset)
      gap_left_ff <= gap_right_ff)
      else $error("gap left edge passed right edge");

   a_gap_bound: assert property (@(posedge clock) disable iff (reset)
      gap_right_ff <= CW'(DEPTH))
      else $error("gap right edge beyond store");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != S_IDLE)
      else $error("item accepted but sequencer stayed idle");

   a_copy_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_COPY_RD) |-> remain_ff != '0)
      else $error("copy loop entered with nothing to copy");

endmodule
